### rtl/rbcb_pkg.sv
// rbcb_pkg: shared constants, types and helpers for the read base-context binner
// no dependencies; imported by every rtl module of the block

package rbcb_pkg;

  localparam int WINDOW_MAX_DEF = 16;

  localparam int BASE_W   = 8;
  localparam int QUAL_W   = 8;
  localparam int POS_W    = 32;
  localparam int WIN_CFG_W = 5;
  localparam int DIMER_W  = 5;
  localparam int GC_W     = 4;
  localparam int RUN_W    = 5;
  localparam int QBIN_W   = 6;

  localparam logic [DIMER_W-1:0] DIMER_NONE = DIMER_W'(16);
  localparam logic [GC_W-1:0]    GC_TOP     = GC_W'(15);
  localparam logic [RUN_W-1:0]   RUN_TOP    = RUN_W'(24);
  localparam logic [QUAL_W-1:0]  QUAL_TOP   = QUAL_W'(40);

  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;

  // per-transaction control handed to the stateful units
  typedef struct packed {
    logic fire;   // one base is consumed this cycle
    logic clear;  // base was the last of its read
  } step_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_code;
    logic [QUAL_W-1:0] quality;
    logic [POS_W-1:0]  position_offset;
    logic              last_of_read;
  } in_item_t;

  typedef struct packed {
    logic [DIMER_W-1:0] dimer;
    logic [GC_W-1:0]    gc_count;
    logic [RUN_W-1:0]   run_length;
    logic [QBIN_W-1:0]  quality_bin;
    logic [POS_W-1:0]   position;
    logic               read_end;
  } out_item_t;

  function automatic logic is_n_base(input logic [BASE_W-1:0] code);
    return |code[BASE_W-1:2];
  endfunction

  function automatic logic is_gc_base(input logic [BASE_W-1:0] code);
    return !is_n_base(code) && (code[1:0] == BASE_C || code[1:0] == BASE_G);
  endfunction

endpackage

### rtl/rbcb_gc_window.sv
// rbcb_gc_window: g/c history shift register and running window total
// depends on rbcb_pkg

module rbcb_gc_window
  import rbcb_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  step_t                step,
  input  logic                 cur_gc,
  input  logic [WIN_CFG_W-1:0] window_len,
  output logic [GC_W-1:0]      gc_count
);

  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int TOT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (TOT_W > GC_W) ? TOT_W : GC_W;

  logic [WINDOW_MAX-1:0] history;
  logic [WINDOW_MAX-1:0] history_next;
  logic [TOT_W-1:0]      total;
  logic [TOT_W-1:0]      total_inc;
  logic [TOT_W-1:0]      total_next;
  logic [WIN_W-1:0]      win;
  logic                  old_gc;
  logic [CMP_W-1:0]      total_ext;

  always_comb begin
    win = (32'(window_len) > WINDOW_MAX) ? WIN_W'(WINDOW_MAX) : WIN_W'(window_len);
    if (win == '0) begin
      old_gc = cur_gc;
    end else begin
      old_gc = history[IDX_W'(win - WIN_W'(1))];
    end
    // add first, then drop the bit leaving the window, both saturating
    total_inc  = (cur_gc && (32'(total) < WINDOW_MAX)) ? total + TOT_W'(1) : total;
    total_next = (old_gc && total_inc != '0) ? total_inc - TOT_W'(1) : total_inc;
    history_next = (history << 1) | WINDOW_MAX'(cur_gc);
    total_ext = CMP_W'(total);
    gc_count  = (total_ext > CMP_W'(GC_TOP)) ? GC_TOP : GC_W'(total_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      total   <= '0;
    end else if (step.fire) begin
      if (step.clear) begin
        history <= '0;
        total   <= '0;
      end else begin
        history <= history_next;
        total   <= total_next;
      end
    end
  end

endmodule

### rtl/rbcb_context.sv
// rbcb_context: previous base, homopolymer run, base index and result field assembly
// depends on rbcb_pkg

module rbcb_context
  import rbcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  step_t             step,
  input  in_item_t          item,
  output logic              has_result,
  output logic [DIMER_W-1:0] dimer,
  output logic [RUN_W-1:0]  run_length,
  output logic [QBIN_W-1:0] quality_bin,
  output logic [POS_W-1:0]  position
);

  logic              prev_valid;
  logic [1:0]        prev_code;
  logic [RUN_W-1:0]  run;
  logic [POS_W-1:0]  index;
  logic              is_n;
  logic [1:0]        code;
  logic [RUN_W-1:0]  run_next;

  always_comb begin
    is_n = is_n_base(item.base_code);
    code = item.base_code[1:0];
    if (is_n || !prev_valid) begin
      dimer = DIMER_NONE;
    end else begin
      dimer = {1'b0, prev_code, code};
    end
    if (is_n) begin
      run_next = '0;
    end else if (prev_valid && prev_code == code) begin
      run_next = (run < RUN_TOP) ? run + RUN_W'(1) : run;
    end else begin
      run_next = '0;
    end
    run_length  = run_next;
    quality_bin = (item.quality > QUAL_TOP) ? QBIN_W'(QUAL_TOP) : QBIN_W'(item.quality);
    position    = item.position_offset + index;
    // first base of a read, or an index that wrapped to zero, gives nothing
    has_result  = (index != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      prev_code  <= '0;
      run        <= '0;
      index      <= '0;
    end else if (step.fire) begin
      if (step.clear) begin
        prev_valid <= 1'b0;
        prev_code  <= '0;
        run        <= '0;
        index      <= '0;
      end else begin
        prev_valid <= !is_n;
        prev_code  <= code;
        run        <= run_next;
        index      <= index + POS_W'(1);
      end
    end
  end

endmodule

### rtl/read_base_context_binner_top.sv
// read_base_context_binner_top: input register, per-base context units, result register
// depends on rbcb_pkg, rbcb_gc_window, rbcb_context
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_stall  | base_code, quality, position_offset, last_of_read
//   out     | out_valid / out_stall| dimer, gc_count, run_length, quality_bin,
//           |                      | position, read_end
//   cfg     | cfg_write            | cfg_data (window length)
//
// one base per cycle sustained while the result is not stalled; a transaction
// is held in the input register, where the context state is updated, then
// sits in the result register; valid rises when a base with a result moves in.
// rst is synchronous and clears the window setting and all per-read state.
// a held result stalls the input register only; in_stall rises when both
// registers are full and the result is stalled.

module read_base_context_binner_top
  import rbcb_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [WIN_CFG_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BASE_W-1:0]    base_code,
  input  logic [QUAL_W-1:0]    quality,
  input  logic [POS_W-1:0]     position_offset,
  input  logic                 last_of_read,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIMER_W-1:0]   dimer,
  output logic [GC_W-1:0]      gc_count,
  output logic [RUN_W-1:0]     run_length,
  output logic [QBIN_W-1:0]    quality_bin,
  output logic [POS_W-1:0]     position,
  output logic                 read_end
);

  logic [WIN_CFG_W-1:0] window_len;
  in_item_t             s1_item;
  logic                 s1_valid;
  logic                 s1_move;
  logic                 in_take;
  step_t                step;
  out_item_t            res;
  out_item_t            res_next;
  logic                 has_result;

  always_comb begin
    s1_move    = s1_valid && (!out_valid || !out_stall);
    in_stall   = s1_valid && !s1_move;
    in_take    = in_valid && !in_stall;
    step.fire  = s1_move;
    step.clear = s1_item.last_of_read;
  end

  rbcb_gc_window #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_gc (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cur_gc    (is_gc_base(s1_item.base_code)),
    .window_len(window_len),
    .gc_count  (res_next.gc_count)
  );

  rbcb_context u_ctx (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (s1_item),
    .has_result (has_result),
    .dimer      (res_next.dimer),
    .run_length (res_next.run_length),
    .quality_bin(res_next.quality_bin),
    .position   (res_next.position)
  );

  assign res_next.read_end = s1_item.last_of_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= '0;
    end else if (cfg_write) begin
      window_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.base_code       <= base_code;
      s1_item.quality         <= quality;
      s1_item.position_offset <= position_offset;
      s1_item.last_of_read    <= last_of_read;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res <= res_next;
    end
  end

  assign dimer       = res.dimer;
  assign gc_count    = res.gc_count;
  assign run_length  = res.run_length;
  assign quality_bin = res.quality_bin;
  assign position    = res.position;
  assign read_end    = res.read_end;

endmodule
